// ----- sv/vna_pkg.sv -----
`timescale 1ns / 1ps
package vna_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int ACCUM_WIDTH_DEF  = 24;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 32;
    localparam int NORM_W = 16;
    localparam int CNT_W  = 6;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_FETCH,
        S_EDGE,
        S_CROSS,
        S_ACC_RD,
        S_ACC_LOAD,
        S_MAG,
        S_SHIFT,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_STORE,
        S_CORNER_RD,
        S_CORNER_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic             in_ready;
        logic             load_item;
        logic             clear_wr;
        logic             wr_vertex;
        logic             pos_rd;
        logic             pos_cap;
        logic             edge_calc;
        logic             mul_issue;
        logic             mul_take;
        logic             sq_mode;
        logic             acc_rd;
        logic             acc_load;
        logic             mag;
        logic             shift;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             div_init;
        logic             div_step;
        logic             div_store;
        logic             corner_wr;
        logic             res_load;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       sel;
    } vna_cmd_t;

    typedef struct packed {
        logic       item_valid;
        logic [1:0] op;
        logic       clear_last;
        logic       vec_zero;
        logic       mag_big;
        logic       out_free;
    } vna_status_t;

endpackage

// ----- sv/vna_in_if.sv -----
`timescale 1ns / 1ps
interface vna_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 operation;
    logic [vna_pkg::IDX_W-1:0]  vertex_index;
    logic signed [31:0]         pos_x;
    logic signed [31:0]         pos_y;
    logic signed [31:0]         pos_z;
    logic [vna_pkg::IDX_W-1:0]  corner_a;
    logic [vna_pkg::IDX_W-1:0]  corner_b;
    logic [vna_pkg::IDX_W-1:0]  corner_c;

    modport source (
        output valid, operation, vertex_index, pos_x, pos_y, pos_z,
               corner_a, corner_b, corner_c,
        input  ready
    );
    modport sink (
        input  valid, operation, vertex_index, pos_x, pos_y, pos_z,
               corner_a, corner_b, corner_c,
        output ready
    );
endinterface

// ----- sv/vna_out_if.sv -----
`timescale 1ns / 1ps
interface vna_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               zero_length;

    modport source (
        output valid, result_kind, normal_x, normal_y, normal_z, zero_length,
        input  ready
    );
    modport sink (
        input  valid, result_kind, normal_x, normal_y, normal_z, zero_length,
        output ready
    );
endinterface

// ----- sv/vna_ram.sv -----
`timescale 1ns / 1ps
module vna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- sv/vna_ctrl.sv -----
`timescale 1ns / 1ps
module vna_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vna_pkg::vna_status_t status,
    output vna_pkg::vna_cmd_t    cmd
);
    import vna_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (status.item_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = '0;
                sel_next = '0;
                if (status.op == OP_WRITE)
                begin
                    state_next = S_WRITE;
                end
                else if (status.op == OP_TRI)
                begin
                    state_next = S_FETCH;
                end
                else if (status.op == OP_READ)
                begin
                    state_next = S_ACC_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_FETCH:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                cnt_next   = '0;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(6))
                begin
                    state_next = S_MAG;
                end
            end
            S_ACC_RD:
            begin
                state_next = S_ACC_LOAD;
            end
            S_ACC_LOAD:
            begin
                state_next = S_MAG;
            end
            S_MAG:
            begin
                state_next = status.vec_zero ? S_RESULT : S_SHIFT;
            end
            S_SHIFT:
            begin
                cnt_next = '0;
                if (!status.mag_big)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    state_next = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT:
            begin
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(31))
                begin
                    sel_next   = '0;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(16))
                begin
                    state_next = S_DIV_STORE;
                end
            end
            S_DIV_STORE:
            begin
                if (sel_reg == 2'd2)
                begin
                    sel_next   = '0;
                    state_next = (status.op == OP_TRI) ? S_CORNER_RD : S_RESULT;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_DIV_INIT;
                end
            end
            S_CORNER_RD:
            begin
                state_next = S_CORNER_WR;
            end
            S_CORNER_WR:
            begin
                if (sel_reg == 2'd2)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_CORNER_RD;
                end
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        cmd.cnt = cnt_reg;
        cmd.sel = sel_reg;
        unique case (state_reg)
            S_CLEAR:     cmd.clear_wr = 1'b1;
            S_IDLE:
            begin
                cmd.in_ready  = 1'b1;
                cmd.load_item = status.item_valid;
            end
            S_WRITE:     cmd.wr_vertex = 1'b1;
            S_FETCH:
            begin
                cmd.pos_rd  = (cnt_reg != CNT_W'(3));
                cmd.pos_cap = (cnt_reg != '0);
                cmd.sel     = cnt_reg[1:0];
            end
            S_EDGE:      cmd.edge_calc = 1'b1;
            S_CROSS:
            begin
                cmd.mul_issue = (cnt_reg != CNT_W'(6));
                cmd.mul_take  = (cnt_reg != '0);
            end
            S_ACC_RD:    cmd.acc_rd = 1'b1;
            S_ACC_LOAD:  cmd.acc_load = 1'b1;
            S_MAG:       cmd.mag = 1'b1;
            S_SHIFT:     cmd.shift = 1'b1;
            S_SQ:
            begin
                cmd.sq_mode   = 1'b1;
                cmd.mul_issue = (cnt_reg != CNT_W'(3));
                cmd.mul_take  = (cnt_reg != '0);
            end
            S_SQRT_INIT: cmd.sqrt_init = 1'b1;
            S_SQRT:      cmd.sqrt_step = 1'b1;
            S_DIV_INIT:  cmd.div_init = 1'b1;
            S_DIV:       cmd.div_step = 1'b1;
            S_DIV_STORE: cmd.div_store = 1'b1;
            S_CORNER_RD: cmd.acc_rd = 1'b1;
            S_CORNER_WR: cmd.corner_wr = 1'b1;
            S_RESULT:    cmd.res_load = status.out_free;
            default:     cmd.cnt = cnt_reg;
        endcase
    end
endmodule

// ----- sv/vna_datapath.sv -----
`timescale 1ns / 1ps
module vna_datapath #(
    parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF,
    parameter int ACCUM_WIDTH  = vna_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    vna_in_if.sink               item,
    vna_out_if.source            result,
    input  vna_pkg::vna_cmd_t    cmd,
    output vna_pkg::vna_status_t status
);
    import vna_pkg::*;

    localparam int AW  = $clog2(VERTEX_DEPTH);
    localparam int ACW = ACCUM_WIDTH;

    function automatic logic edge_big(input logic [32:0] e);
        return (e[32] != e[31]) || (e == {1'b1, 32'h8000_0000});
    endfunction

    function automatic logic [31:0] halve(input logic [32:0] e);
        logic [32:0] t;
        t = e + {32'd0, e[32]};
        return t[32:1];
    endfunction

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return {22'd0, idx} < 32'(VERTEX_DEPTH);
    endfunction

    logic [1:0]       op_reg;
    logic [IDX_W-1:0] vi_reg, ca_reg, cb_reg, cc_reg;
    pos_t             wpos_reg;

    logic [AW-1:0]    clr_addr_reg;

    pos_t             p_reg [3];
    logic             rd_ok_reg;
    logic [31:0]      e1_reg [3];
    logic [31:0]      e2_reg [3];

    logic [63:0]      prod_reg;
    logic [63:0]      c_reg [3];
    logic [63:0]      m_reg [3];
    logic [63:0]      s_reg, r_reg, bit_reg;
    logic [49:0]      rem_reg;
    logic [16:0]      q_reg;
    logic [15:0]      n_reg [3];
    logic             zero_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [15:0]      out_n_reg [3];
    logic             out_zero_reg;

    logic [IDX_W-1:0] corner_idx;
    logic             corner_ok;
    logic             vi_ok;

    logic [3*POS_W-1:0] pos_rdata;
    logic [3*ACW-1:0]   acc_rdata;
    logic               acc_we;
    logic [AW-1:0]      acc_waddr;
    logic [3*ACW-1:0]   acc_wdata;
    logic [AW-1:0]      acc_raddr;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_full;
    logic [CNT_W-1:0]   take_idx;

    logic [30:0]        a_sel;
    logic               c_sign_sel;
    logic [47:0]        num;
    logic [49:0]        dsh;
    logic               ge;
    logic [63:0]        rb;
    logic [16:0]        q_sat;
    logic [15:0]        n_val;
    logic [ACW-1:0]     acc_sum [3];
    logic [ACW:0]       acc_wide [3];

    always_comb
    begin
        unique case (cmd.sel)
            2'd0:    corner_idx = ca_reg;
            2'd1:    corner_idx = cb_reg;
            default: corner_idx = cc_reg;
        endcase
    end
    assign corner_ok = idx_ok(corner_idx);
    assign vi_ok     = idx_ok(vi_reg);

    // position store
    vna_ram #(.WIDTH(3*POS_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_vertex && vi_ok),
        .wr_addr (AW'(vi_reg)),
        .wr_data (wpos_reg),
        .rd_en   (cmd.pos_rd),
        .rd_addr (AW'(corner_idx)),
        .rd_data (pos_rdata)
    );

    // accumulator store
    always_comb
    begin
        acc_we    = 1'b0;
        acc_waddr = AW'(corner_idx);
        acc_wdata = {acc_sum[0], acc_sum[1], acc_sum[2]};
        priority if (cmd.clear_wr)
        begin
            acc_we    = 1'b1;
            acc_waddr = clr_addr_reg;
            acc_wdata = '0;
        end
        else if (cmd.wr_vertex)
        begin
            acc_we    = vi_ok;
            acc_waddr = AW'(vi_reg);
            acc_wdata = '0;
        end
        else if (cmd.corner_wr)
        begin
            acc_we = corner_ok;
        end
    end
    assign acc_raddr = (op_reg == OP_READ) ? AW'(vi_reg) : AW'(corner_idx);

    vna_ram #(.WIDTH(3*ACW), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
        .clk     (clk),
        .wr_en   (acc_we),
        .wr_addr (acc_waddr),
        .wr_data (acc_wdata),
        .rd_en   (cmd.acc_rd),
        .rd_addr (acc_raddr),
        .rd_data (acc_rdata)
    );

    // saturating accumulate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_wide[i] = {acc_rdata[(3-i)*ACW-1], acc_rdata[(3-i)*ACW-1 -: ACW]}
                          + {{(ACW+1-NORM_W){n_reg[i][15]}}, n_reg[i]};
            if (acc_wide[i][ACW] != acc_wide[i][ACW-1])
            begin
                acc_sum[i] = acc_wide[i][ACW] ? {1'b1, {(ACW-1){1'b0}}}
                                              : {1'b0, {(ACW-1){1'b1}}};
            end
            else
            begin
                acc_sum[i] = acc_wide[i][ACW-1:0];
            end
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_mode)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cmd.cnt == CNT_W'(i))
                begin
                    mul_a = {2'b00, m_reg[i][30:0]};
                    mul_b = {2'b00, m_reg[i][30:0]};
                end
            end
        end
        else
        begin
            unique case (cmd.cnt)
                CNT_W'(0): begin mul_a = 33'(signed'(e1_reg[1])); mul_b = 33'(signed'(e2_reg[2])); end
                CNT_W'(1): begin mul_a = 33'(signed'(e1_reg[2])); mul_b = 33'(signed'(e2_reg[1])); end
                CNT_W'(2): begin mul_a = 33'(signed'(e1_reg[2])); mul_b = 33'(signed'(e2_reg[0])); end
                CNT_W'(3): begin mul_a = 33'(signed'(e1_reg[0])); mul_b = 33'(signed'(e2_reg[2])); end
                CNT_W'(4): begin mul_a = 33'(signed'(e1_reg[0])); mul_b = 33'(signed'(e2_reg[1])); end
                CNT_W'(5): begin mul_a = 33'(signed'(e1_reg[1])); mul_b = 33'(signed'(e2_reg[0])); end
                default:   begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end
    assign prod_full = mul_a * mul_b;
    assign take_idx  = cmd.cnt - 1'b1;

    // divider and component select
    always_comb
    begin
        a_sel      = '0;
        c_sign_sel = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.sel == 2'(i))
            begin
                a_sel      = m_reg[i][30:0];
                c_sign_sel = c_reg[i][63];
            end
        end
    end
    assign num = {1'b0, a_sel, 16'd0} + {16'd0, r_reg[31:0]};
    assign dsh = {17'd0, r_reg[31:0], 1'b0} << (5'd16 - cmd.cnt[4:0]);
    assign ge  = rem_reg >= dsh;
    assign rb  = r_reg + bit_reg;

    always_comb
    begin
        if (c_sign_sel)
        begin
            q_sat = (q_reg > 17'd32768) ? 17'd32768 : q_reg;
            n_val = 16'(17'd0 - q_sat);
        end
        else
        begin
            q_sat = (q_reg > 17'd32767) ? 17'd32767 : q_reg;
            n_val = q_sat[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= item.operation;
            vi_reg     <= item.vertex_index;
            wpos_reg.x <= item.pos_x;
            wpos_reg.y <= item.pos_y;
            wpos_reg.z <= item.pos_z;
            ca_reg     <= item.corner_a;
            cb_reg     <= item.corner_b;
            cc_reg     <= item.corner_c;
        end
        rd_ok_reg <= corner_ok;
        if (cmd.pos_cap)
        begin
            p_reg[0] <= p_reg[1];
            p_reg[1] <= p_reg[2];
            p_reg[2] <= rd_ok_reg ? pos_t'(pos_rdata) : '0;
        end
        if (cmd.edge_calc)
        begin
            logic [32:0] d1 [3];
            logic [32:0] d2 [3];
            logic        big;
            d1[0] = {p_reg[1].x[31], p_reg[1].x} - {p_reg[0].x[31], p_reg[0].x};
            d1[1] = {p_reg[1].y[31], p_reg[1].y} - {p_reg[0].y[31], p_reg[0].y};
            d1[2] = {p_reg[1].z[31], p_reg[1].z} - {p_reg[0].z[31], p_reg[0].z};
            d2[0] = {p_reg[2].x[31], p_reg[2].x} - {p_reg[1].x[31], p_reg[1].x};
            d2[1] = {p_reg[2].y[31], p_reg[2].y} - {p_reg[1].y[31], p_reg[1].y};
            d2[2] = {p_reg[2].z[31], p_reg[2].z} - {p_reg[1].z[31], p_reg[1].z};
            big = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                big = big | edge_big(d1[i]) | edge_big(d2[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= big ? halve(d1[i]) : d1[i][31:0];
                e2_reg[i] <= big ? halve(d2[i]) : d2[i][31:0];
            end
        end
        if (cmd.mul_issue)
        begin
            prod_reg <= prod_full[63:0];
        end
        if (cmd.mul_take)
        begin
            if (cmd.sq_mode)
            begin
                s_reg <= (take_idx == '0) ? prod_reg : s_reg + prod_reg;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (take_idx[2:1] == 2'(i))
                    begin
                        c_reg[i] <= take_idx[0] ? c_reg[i] - prod_reg : prod_reg;
                    end
                end
            end
        end
        if (cmd.acc_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= vi_ok ? 64'(signed'(acc_rdata[(3-i)*ACW-1 -: ACW])) : '0;
            end
        end
        if (cmd.mag)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= c_reg[i][63] ? 64'd0 - c_reg[i] : c_reg[i];
                n_reg[i] <= '0;
            end
            zero_reg <= status.vec_zero;
        end
        if (cmd.shift && status.mag_big)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= m_reg[i] >> 1;
            end
        end
        if (cmd.sqrt_init)
        begin
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        if (cmd.sqrt_step)
        begin
            if (s_reg >= rb)
            begin
                s_reg <= s_reg - rb;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            rem_reg <= {2'b00, num};
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? rem_reg - dsh : rem_reg;
            q_reg   <= {q_reg[15:0], ge};
        end
        if (cmd.div_store)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cmd.sel == 2'(i))
                begin
                    n_reg[i] <= n_val;
                end
            end
        end
        if (cmd.res_load)
        begin
            out_kind_reg <= (op_reg == OP_READ) ? KIND_VERTEX : KIND_FACE;
            out_zero_reg <= zero_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_n_reg[i] <= n_reg[i];
            end
        end
    end

    assign item.ready         = cmd.in_ready;
    assign result.valid       = out_valid_reg;
    assign result.result_kind = out_kind_reg;
    assign result.normal_x    = out_n_reg[0];
    assign result.normal_y    = out_n_reg[1];
    assign result.normal_z    = out_n_reg[2];
    assign result.zero_length = out_zero_reg;

    assign status.item_valid = item.valid;
    assign status.op         = op_reg;
    assign status.clear_last = (clr_addr_reg == AW'(VERTEX_DEPTH - 1));
    assign status.vec_zero   = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
    assign status.mag_big    = (m_reg[0] > 64'h4000_0000) || (m_reg[1] > 64'h4000_0000)
                               || (m_reg[2] > 64'h4000_0000);
    assign status.out_free   = !out_valid_reg || result.ready;
endmodule

// ----- sv/vertex_normal_accumulator_top.sv -----
`timescale 1ns / 1ps
// vertex normal accumulator
// item channel (valid/ready): write vertex, add triangle or read vertex normal.
// result channel (valid/ready): face normal of a triangle or normalized vertex
// normal, Q1.15, one transfer per triangle or read; writes give none.
// one item at a time; a zero vector skips normalization. the time is set by
// the shared 33x33 multiplier (6 cross products, 3 squares), the one-bit-per-cycle
// range shift, the 32-step square root and one 17-step divider run for each of
// the three components, plus the accumulator read-modify-write for each corner.
// after reset the accumulator store is cleared while item ready stays low;
// positions are undefined until written.
// the result sits in an output register: the next item is taken while it
// waits, and a new result is held back until the receiver takes the old one.
module vertex_normal_accumulator_top #(
    parameter int VERTEX_DEPTH = vna_pkg::VERTEX_DEPTH_DEF,
    parameter int ACCUM_WIDTH  = vna_pkg::ACCUM_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    vna_in_if.sink    item,
    vna_out_if.source result
);
    import vna_pkg::*;

    vna_cmd_t    cmd;
    vna_status_t status;

    vna_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    vna_datapath #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .ACCUM_WIDTH  (ACCUM_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import vna_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam longint ACC_HI = (longint'(1) <<< (ACCUM_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint EDGE_LIM = (longint'(1) <<< 31) - 1;

    typedef struct {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [31:0]      px, py, pz;
        logic [IDX_W-1:0] ca, cb, cc;
    } mesh_cmd_t;

    typedef struct {
        logic        kind;
        logic [15:0] nx, ny, nz;
        logic        zero;
    } normal_t;

    class normal_board;
        longint  vx[VERTEX_DEPTH_DEF], vy[VERTEX_DEPTH_DEF], vz[VERTEX_DEPTH_DEF];
        longint  ax[VERTEX_DEPTH_DEF], ay[VERTEX_DEPTH_DEF], az[VERTEX_DEPTH_DEF];
        normal_t due_normals[$];
        int      errors;

        function new();
            errors = 0;
            for (int i = 0; i < VERTEX_DEPTH_DEF; i++)
            begin
                vx[i] = 0; vy[i] = 0; vz[i] = 0;
                ax[i] = 0; ay[i] = 0; az[i] = 0;
            end
        endfunction

        function longint unsigned int_root(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = longint'(1) <<< 62;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function normal_t unit_normal(logic kind, longint cx, longint cy, longint cz);
            longint          c[3];
            longint unsigned m[3], a[3];
            longint unsigned len, q;
            int              sh;
            logic [15:0]     n[3];
            normal_t         r;
            c[0] = cx; c[1] = cy; c[2] = cz;
            r.kind = kind;
            for (int i = 0; i < 3; i++)
                m[i] = mag(c[i]);
            if (m[0] == 0 && m[1] == 0 && m[2] == 0)
            begin
                r.nx = 0; r.ny = 0; r.nz = 0; r.zero = 1'b1;
                return r;
            end
            sh = 0;
            while ((m[0] >> sh) > (64'd1 << 30) || (m[1] >> sh) > (64'd1 << 30)
                   || (m[2] >> sh) > (64'd1 << 30))
                sh++;
            for (int i = 0; i < 3; i++)
                a[i] = m[i] >> sh;
            len = int_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
            for (int i = 0; i < 3; i++)
            begin
                q = ((a[i] << 16) + len) / (2 * len);
                if (c[i] < 0)
                begin
                    if (q > 32768)
                        q = 32768;
                    n[i] = 16'(-longint'(q));
                end
                else
                begin
                    if (q > 32767)
                        q = 32767;
                    n[i] = 16'(q);
                end
            end
            r.nx = n[0]; r.ny = n[1]; r.nz = n[2]; r.zero = 1'b0;
            return r;
        endfunction

        function longint sat_acc(longint acc, logic signed [15:0] v);
            longint s;
            s = acc + v;
            if (s > ACC_HI)
                s = ACC_HI;
            if (s < ACC_LO)
                s = ACC_LO;
            return s;
        endfunction

        function void note_item(mesh_cmd_t it);
            longint  e1[3], e2[3];
            int      k[3];
            bit      big;
            normal_t r;
            case (it.op)
                OP_WRITE:
                begin
                    vx[it.idx] = longint'(signed'(it.px));
                    vy[it.idx] = longint'(signed'(it.py));
                    vz[it.idx] = longint'(signed'(it.pz));
                    ax[it.idx] = 0; ay[it.idx] = 0; az[it.idx] = 0;
                end
                OP_TRI:
                begin
                    k[0] = it.ca; k[1] = it.cb; k[2] = it.cc;
                    e1[0] = vx[k[1]] - vx[k[0]]; e2[0] = vx[k[2]] - vx[k[1]];
                    e1[1] = vy[k[1]] - vy[k[0]]; e2[1] = vy[k[2]] - vy[k[1]];
                    e1[2] = vz[k[1]] - vz[k[0]]; e2[2] = vz[k[2]] - vz[k[1]];
                    big = 0;
                    for (int i = 0; i < 3; i++)
                        if (mag(e1[i]) > EDGE_LIM || mag(e2[i]) > EDGE_LIM)
                            big = 1;
                    if (big)
                        for (int i = 0; i < 3; i++)
                        begin
                            e1[i] = e1[i] / 2;
                            e2[i] = e2[i] / 2;
                        end
                    r = unit_normal(KIND_FACE, e1[1] * e2[2] - e1[2] * e2[1],
                                    e1[2] * e2[0] - e1[0] * e2[2],
                                    e1[0] * e2[1] - e1[1] * e2[0]);
                    for (int i = 0; i < 3; i++)
                    begin
                        ax[k[i]] = sat_acc(ax[k[i]], r.nx);
                        ay[k[i]] = sat_acc(ay[k[i]], r.ny);
                        az[k[i]] = sat_acc(az[k[i]], r.nz);
                    end
                    due_normals.insert(due_normals.size(), r);
                end
                OP_READ:
                begin
                    r = unit_normal(KIND_VERTEX, ax[it.idx], ay[it.idx], az[it.idx]);
                    due_normals.insert(due_normals.size(), r);
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(normal_t got);
            normal_t w;
            if (due_normals.size() == 0)
            begin
                report("unexpected result");
                return;
            end
            w = due_normals.pop_front();
            if (got.kind !== w.kind)
                report($sformatf("result_kind %b want %b", got.kind, w.kind));
            if (got.nx !== w.nx)
                report($sformatf("normal_x %h want %h", got.nx, w.nx));
            if (got.ny !== w.ny)
                report($sformatf("normal_y %h want %h", got.ny, w.ny));
            if (got.nz !== w.nz)
                report($sformatf("normal_z %h want %h", got.nz, w.nz));
            if (got.zero !== w.zero)
                report($sformatf("zero_length %b want %b", got.zero, w.zero));
        endtask
    endclass

    logic clk = 0;
    logic rst_n;
    vna_in_if  in_ch();
    vna_out_if out_ch();

    vertex_normal_accumulator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    normal_board board = new();
    int          idle_mode = 0;
    int          hold_asks = 0;
    int          placed[$];
    int          pool[$];

    always @(posedge clk)
    begin
        int seen;
        int hold_left;
        normal_t got;
        if (rst_n === 1'b1 && out_ch.valid && out_ch.ready)
        begin
            got.kind = out_ch.result_kind;
            got.nx = out_ch.normal_x;
            got.ny = out_ch.normal_y;
            got.nz = out_ch.normal_z;
            got.zero = out_ch.zero_length;
            board.check_result(got);
        end
        if (seen != hold_asks)
        begin
            seen = hold_asks;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_mode == 0)
            out_ch.ready <= ($urandom_range(99) >= 87);
        else if (idle_mode == 1)
            out_ch.ready <= ($urandom_range(99) >= 8);
        else
            out_ch.ready <= 1'b1;
    end

    task send(mesh_cmd_t it);
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= it.op;
        in_ch.vertex_index <= it.idx;
        in_ch.pos_x        <= it.px;
        in_ch.pos_y        <= it.py;
        in_ch.pos_z        <= it.pz;
        in_ch.corner_a     <= it.ca;
        in_ch.corner_b     <= it.cb;
        in_ch.corner_c     <= it.cc;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_item(it);
        if ((idle_mode == 0 && $urandom_range(99) < 8)
            || (idle_mode == 1 && $urandom_range(99) < 87))
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic mesh_cmd_t noise_cmd(logic [1:0] op);
        mesh_cmd_t it;
        it.op = op;
        it.idx = IDX_W'($urandom);
        it.px = $urandom; it.py = $urandom; it.pz = $urandom;
        it.ca = IDX_W'($urandom); it.cb = IDX_W'($urandom); it.cc = IDX_W'($urandom);
        return it;
    endfunction

    task put_vertex(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        mesh_cmd_t it;
        it = noise_cmd(OP_WRITE);
        it.idx = IDX_W'(idx); it.px = x; it.py = y; it.pz = z;
        placed.insert(placed.size(), idx);
        send(it);
    endtask

    task put_tri(int a, int b, int c);
        mesh_cmd_t it;
        it = noise_cmd(OP_TRI);
        it.ca = IDX_W'(a); it.cb = IDX_W'(b); it.cc = IDX_W'(c);
        send(it);
    endtask

    task get_normal(int idx);
        mesh_cmd_t it;
        it = noise_cmd(OP_READ);
        it.idx = IDX_W'(idx);
        send(it);
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return 32'h8000_0000 + $urandom_range(3);
            3: return $urandom_range(7);
            default: return 32'($signed($urandom_range(2000000)) - 1000000) << 4;
        endcase
    endfunction

    function automatic int corner();
        if ($urandom_range(3) != 0)
            return pool[$urandom_range(pool.size() - 1)];
        return placed[$urandom_range(placed.size() - 1)];
    endfunction

    task random_items(int count);
        int w, a;
        for (int i = 0; i < count; i++)
        begin
            w = $urandom_range(99);
            if (w < 10)
            begin
                if ($urandom_range(1))
                    put_vertex(pool[$urandom_range(pool.size() - 1)], coord(), coord(), coord());
                else
                    put_vertex($urandom_range(1023), coord(), coord(), coord());
            end
            else if (w < 62)
                put_tri(corner(), corner(), corner());
            else if (w < 67)
            begin
                a = corner();
                put_tri(a, a, corner());
            end
            else if (w < 95)
                get_normal($urandom_range(3) != 0 ? corner() : $urandom_range(1023));
            else
                send(noise_cmd(OP_NONE));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_WRITE;
        in_ch.vertex_index = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
        in_ch.corner_a = '0; in_ch.corner_b = '0; in_ch.corner_c = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        put_vertex(0, 0, 0, 0);
        put_vertex(1, 32'h0001_0000, 0, 0);
        put_vertex(2, 0, 32'h0001_0000, 0);
        put_tri(0, 1, 2);
        put_tri(0, 2, 1);
        get_normal(0);
        get_normal(700);
        put_vertex(1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        put_vertex(3, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        put_vertex(4, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        put_tri(1023, 3, 4);
        put_tri(0, 0, 1);
        put_vertex(5, 32'h0002_0000, 0, 0);
        put_tri(0, 1, 5);
        put_vertex(6, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
        put_tri(6, 1023, 2);
        send(noise_cmd(OP_NONE));
        get_normal(1023);
        get_normal(1);
        put_vertex(1, 32'h0001_0000, 0, 0);
        get_normal(1);

        for (int i = 0; i < 24; i++)
        begin
            pool.insert(pool.size(), int'($urandom_range(1023)));
            put_vertex(pool[i], coord(), coord(), coord());
        end
        random_items(450);

        idle_mode = 1;
        random_items(250);

        idle_mode = 2;
        hold_asks++;
        put_vertex(10, 0, 0, 0);
        put_vertex(11, 32'h0003_0000, 32'h0001_0000, 0);
        put_vertex(12, 0, 32'h0002_0000, 32'h0001_0000);
        for (int i = 0; i < 270; i++)
            put_tri(10, 11, 12);
        get_normal(10);
        for (int i = 0; i < 380; i++)
            put_tri(10, 12, 11);
        get_normal(11);
        get_normal(12);
        random_items(150);

        in_ch.valid <= 1'b0;
        while (board.due_normals.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
